// ===== design/bilinear_texel_sampler_q8_macros.svh =====
// ----------------------------------------------------------------------------
// Bilinear texel sampler assertion macros
// Concurrent check templates for the sampler coordinate pipeline.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_TEXEL_SAMPLER_Q8_MACROS_SVH
`define BILINEAR_TEXEL_SAMPLER_Q8_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define TBS_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbs: same-cycle check failed");

// Next-cycle implication, disabled while reset is held
`define TBS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbs: next-cycle check failed");

`endif

// ===== design/tbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Bilinear texel sampler package
// Sizes, stage payload types, size saturation, the modulo step and the per-channel blend arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

package tbs_pkg;

    // Texture store geometry
    localparam int unsigned MAX_WIDTH  = 256;
    localparam int unsigned MAX_HEIGHT = 256;
    localparam int unsigned XW         = $clog2(MAX_WIDTH);
    localparam int unsigned YW         = $clog2(MAX_HEIGHT);
    localparam int unsigned ADDR_W     = XW + YW;

    // Field widths
    localparam int unsigned DIM_W   = 9;
    localparam int unsigned COORD_W = 18;
    localparam int unsigned FRAC_W  = 8;
    localparam int unsigned UI_W    = COORD_W - FRAC_W;
    localparam int unsigned COLOR_W = 32;
    localparam int unsigned CH_W    = 8;
    localparam int unsigned IDX_W   = 2;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_TEX_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_TEX_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] CFG_WRAP_MODE  = 2'd2;

    // Action codes
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    typedef struct packed {
        logic [DIM_W-1:0] tex_width;
        logic [DIM_W-1:0] tex_height;
        logic             wrap_mode;
    } t_cfg;

    // Accepted input beat
    typedef struct packed {
        logic               action;
        logic [XW-1:0]      x;
        logic [YW-1:0]      y;
        logic [COLOR_W-1:0] color;
        logic [COORD_W-1:0] u;
        logic [COORD_W-1:0] v;
    } t_beat;

    // Coordinate pipeline payload; rem starts as |ui| and ends as |ui| mod w
    typedef struct packed {
        logic               action;
        logic [ADDR_W-1:0]  wr_addr;
        logic [COLOR_W-1:0] color;
        logic               neg;
        logic [UI_W-1:0]    rem;
        logic [XW-1:0]      xc0;
        logic [XW-1:0]      xc1;
        logic [YW-1:0]      y0;
        logic [YW-1:0]      y1;
        logic [FRAC_W-1:0]  uf;
        logic [FRAC_W-1:0]  vf;
    } t_coord;

    // Store access request
    typedef struct packed {
        logic               action;
        logic [ADDR_W-1:0]  wr_addr;
        logic [COLOR_W-1:0] color;
        logic [XW-1:0]      x0;
        logic [XW-1:0]      x1;
        logic [YW-1:0]      y0;
        logic [YW-1:0]      y1;
        logic [FRAC_W-1:0]  uf;
        logic [FRAC_W-1:0]  vf;
    } t_fetch;

    // Four neighbor texels with their fractions
    typedef struct packed {
        logic [COLOR_W-1:0] t00;
        logic [COLOR_W-1:0] t10;
        logic [COLOR_W-1:0] t01;
        logic [COLOR_W-1:0] t11;
        logic [FRAC_W-1:0]  uf;
        logic [FRAC_W-1:0]  vf;
    } t_texels;

    // Horizontally blended rows
    typedef struct packed {
        logic [COLOR_W-1:0] top;
        logic [COLOR_W-1:0] bot;
        logic [FRAC_W-1:0]  vf;
    } t_rows;

    // Saturate a size register to [1, dmax]
    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] d,
                                                 input logic [DIM_W-1:0] dmax);
        return (d == '0) ? DIM_W'(1) : ((d > dmax) ? dmax : d);
    endfunction

    // One restoring step of rem mod w against w shifted by k
    function automatic logic [UI_W-1:0] mod_step(input logic [UI_W-1:0]  rem,
                                                 input logic [DIM_W-1:0] w,
                                                 input int unsigned      k);
        logic [UI_W+DIM_W-1:0] d;
        d = (UI_W+DIM_W)'(w) << k;
        return ((UI_W+DIM_W)'(rem) >= d) ? (rem - d[UI_W-1:0]) : rem;
    endfunction

    // (a*(256-t) + b*t) >> 8 on one channel
    function automatic logic [CH_W-1:0] blend_ch(input logic [CH_W-1:0]   a,
                                                 input logic [CH_W-1:0]   b,
                                                 input logic [FRAC_W-1:0] t);
        logic [16:0] acc;
        acc = 17'(a) * (17'd256 - 17'(t)) + 17'(b) * 17'(t);
        return acc[15:8];
    endfunction

    // Blend all four channels of two packed colors
    function automatic logic [COLOR_W-1:0] blend_word(input logic [COLOR_W-1:0] a,
                                                      input logic [COLOR_W-1:0] b,
                                                      input logic [FRAC_W-1:0]  t);
        logic [COLOR_W-1:0] res;
        res = '0;
        for (int ch = 0; ch < COLOR_W / CH_W; ch++) begin
            res[ch*CH_W +: CH_W] = blend_ch(a[ch*CH_W +: CH_W], b[ch*CH_W +: CH_W], t);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== design/tbs_ram.sv =====
// ----------------------------------------------------------------------------
// Texel RAM
// One write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module tbs_ram #(
    parameter int unsigned ADDR_W = 16,
    parameter int unsigned DATA_W = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr0,
    input  wire logic [ADDR_W-1:0] i_raddr1,
    output logic      [DATA_W-1:0] o_rdata0,
    output logic      [DATA_W-1:0] o_rdata1
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read ports, hold data while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata0 <= r_mem[i_raddr0];
            o_rdata1 <= r_mem[i_raddr1];
        end
    end

endmodule

`default_nettype wire

// ===== design/tbs_coord.sv =====
// ----------------------------------------------------------------------------
// Sampler coordinate pipeline
// Clamps Q8 coordinates, wraps u by a two-stage modulo, forms neighbor indices.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bilinear_texel_sampler_q8_macros.svh"

module tbs_coord
    import tbs_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_cfg   i_cfg,
    input  wire logic   i_valid,
    output logic        o_ready,
    input  wire t_beat  i_beat,
    output logic        o_valid,
    output t_fetch      o_item,
    input  wire logic   i_ready
);

    localparam int unsigned SPLIT = UI_W / 2;

    logic             r_v1, r_v2, r_v3, r_v4;
    t_beat            r_s1;
    t_coord           r_s2, r_s3, r_s4;
    t_coord           n_s2, n_s3, n_s4;
    logic             rdy1, rdy2, rdy3, rdy4;
    logic [DIM_W-1:0] w, h;

    assign w = sat_dim(i_cfg.tex_width,  DIM_W'(MAX_WIDTH));
    assign h = sat_dim(i_cfg.tex_height, DIM_W'(MAX_HEIGHT));

    // Per-stage ready: a stage moves when it is empty or its successor moves
    assign rdy4    = !r_v4 || i_ready;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v4;

    // Stage 2: clamp coordinates, split integer and fraction
    always_comb begin
        logic [COORD_W-2:0] hi_u, hi_v, ucl, vcl;
        logic [COORD_W-1:0] uc;
        logic [UI_W-1:0]    ui;
        logic [DIM_W-1:0]   nx, ny;
        hi_u = {(COORD_W-1-FRAC_W)'(w - DIM_W'(1)), FRAC_W'(0)};
        hi_v = {(COORD_W-1-FRAC_W)'(h - DIM_W'(1)), FRAC_W'(0)};
        if (r_s1.u[COORD_W-1]) begin
            ucl = '0;
        end else if (r_s1.u[COORD_W-2:0] > hi_u) begin
            ucl = hi_u;
        end else begin
            ucl = r_s1.u[COORD_W-2:0];
        end
        if (r_s1.v[COORD_W-1]) begin
            vcl = '0;
        end else if (r_s1.v[COORD_W-2:0] > hi_v) begin
            vcl = hi_v;
        end else begin
            vcl = r_s1.v[COORD_W-2:0];
        end
        uc = i_cfg.wrap_mode ? r_s1.u : {1'b0, ucl};
        ui = uc[COORD_W-1:FRAC_W];

        n_s2.action  = r_s1.action;
        n_s2.wr_addr = {r_s1.y, r_s1.x};
        n_s2.color   = r_s1.color;
        n_s2.neg     = ui[UI_W-1];
        n_s2.rem     = ui[UI_W-1] ? (~ui + UI_W'(1)) : ui;
        n_s2.uf      = uc[FRAC_W-1:0];
        n_s2.vf      = vcl[FRAC_W-1:0];

        // Clamped horizontal pair
        n_s2.xc0 = ui[XW-1:0];
        nx       = DIM_W'(ui[XW-1:0]) + DIM_W'(1);
        n_s2.xc1 = (nx < w) ? nx[XW-1:0] : ui[XW-1:0];

        // Vertical pair, always clamped
        n_s2.y0 = vcl[FRAC_W +: YW];
        ny      = DIM_W'(vcl[FRAC_W +: YW]) + DIM_W'(1);
        n_s2.y1 = (ny < h) ? ny[YW-1:0] : vcl[FRAC_W +: YW];
    end

    // Stage 3: upper half of the restoring modulo
    always_comb begin
        n_s3 = r_s2;
        for (int k = UI_W - 1; k >= int'(SPLIT); k--) begin
            n_s3.rem = mod_step(n_s3.rem, w, k);
        end
    end

    // Stage 4: lower half of the restoring modulo
    always_comb begin
        n_s4 = r_s3;
        for (int k = SPLIT - 1; k >= 0; k--) begin
            n_s4.rem = mod_step(n_s4.rem, w, k);
        end
    end

    // Output: fold negative remainder, pick wrapped or clamped columns
    always_comb begin
        logic [XW-1:0]    r, x0w;
        logic [DIM_W-1:0] diff, nx;
        r    = r_s4.rem[XW-1:0];
        diff = w - DIM_W'(r);
        x0w  = (r_s4.neg && r != '0) ? diff[XW-1:0] : r;
        nx   = DIM_W'(x0w) + DIM_W'(1);

        o_item.action  = r_s4.action;
        o_item.wr_addr = r_s4.wr_addr;
        o_item.color   = r_s4.color;
        o_item.y0      = r_s4.y0;
        o_item.y1      = r_s4.y1;
        o_item.uf      = r_s4.uf;
        o_item.vf      = r_s4.vf;
        if (i_cfg.wrap_mode) begin
            o_item.x0 = x0w;
            o_item.x1 = (nx == w) ? '0 : nx[XW-1:0];
        end else begin
            o_item.x0 = r_s4.xc0;
            o_item.x1 = r_s4.xc1;
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) r_s1 <= i_beat;
        if (rdy2) r_s2 <= n_s2;
        if (rdy3) r_s3 <= n_s3;
        if (rdy4) r_s4 <= n_s4;
    end

    `TBS_ASSERT_NEXT(a_accept_lands, i_clk, i_rst_n, i_valid && o_ready, r_v1)
    `TBS_ASSERT_NEXT(a_s4_holds, i_clk, i_rst_n, r_v4 && !i_ready, r_v4 && $stable(r_s4))
    `TBS_ASSERT_NOW(a_x_in_width, i_clk, i_rst_n, o_valid && o_item.action == ACT_SAMPLE, (DIM_W'(o_item.x0) < w) && (DIM_W'(o_item.x1) < w))
    `TBS_ASSERT_NOW(a_y_pair, i_clk, i_rst_n, o_valid && o_item.action == ACT_SAMPLE, (o_item.y1 == o_item.y0) || (DIM_W'(o_item.y1) == DIM_W'(o_item.y0) + DIM_W'(1)))

endmodule

`default_nettype wire

// ===== design/tbs_fetch.sv =====
// ----------------------------------------------------------------------------
// Sampler texel fetch
// Two store copies, each reading one row pair, written together on loads.
// ----------------------------------------------------------------------------
`default_nettype none

module tbs_fetch
    import tbs_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    output logic        o_ready,
    input  wire t_fetch i_item,
    output logic        o_valid,
    output t_texels     o_texels,
    input  wire logic   i_ready
);

    logic               r_v5;
    logic [FRAC_W-1:0]  r_uf, r_vf;
    logic               rdy5, we;
    logic [COLOR_W-1:0] rd00, rd10, rd01, rd11;

    assign rdy5    = !r_v5 || i_ready;
    assign o_ready = rdy5;
    assign o_valid = r_v5;
    assign we      = i_valid && rdy5 && i_item.action == ACT_WRITE;

    // Upper row copy
    tbs_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (COLOR_W)
    ) u_ram_top (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (i_item.wr_addr),
        .i_wdata  (i_item.color),
        .i_re     (rdy5),
        .i_raddr0 ({i_item.y0, i_item.x0}),
        .i_raddr1 ({i_item.y0, i_item.x1}),
        .o_rdata0 (rd00),
        .o_rdata1 (rd10)
    );

    // Lower row copy
    tbs_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (COLOR_W)
    ) u_ram_bot (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (i_item.wr_addr),
        .i_wdata  (i_item.color),
        .i_re     (rdy5),
        .i_raddr0 ({i_item.y1, i_item.x0}),
        .i_raddr1 ({i_item.y1, i_item.x1}),
        .o_rdata0 (rd01),
        .o_rdata1 (rd11)
    );

    // Gather the four neighbors with their fractions
    assign o_texels = {rd00, rd10, rd01, rd11, r_uf, r_vf};

    // Drop write beats here; only samples go on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (rdy5) begin
            r_v5 <= i_valid && i_item.action == ACT_SAMPLE;
        end
    end

    // Hold fractions alongside the read data
    always_ff @(posedge i_clk) begin
        if (rdy5) begin
            r_uf <= i_item.uf;
            r_vf <= i_item.vf;
        end
    end

endmodule

`default_nettype wire

// ===== design/tbs_blend.sv =====
// ----------------------------------------------------------------------------
// Sampler blend pipeline
// Blends along u per row, then along v, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tbs_blend
    import tbs_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire t_texels      i_texels,
    output logic              o_valid,
    output logic [COLOR_W-1:0] o_color,
    input  wire logic         i_ready
);

    logic               r_v6, r_v7;
    t_rows              r_rows, n_rows;
    logic [COLOR_W-1:0] r_color;
    logic               rdy6, rdy7;

    assign rdy7    = !r_v7 || i_ready;
    assign rdy6    = !r_v6 || rdy7;
    assign o_ready = rdy6;
    assign o_valid = r_v7;
    assign o_color = r_color;

    // Horizontal blend of both rows
    always_comb begin
        n_rows.top = blend_word(i_texels.t00, i_texels.t10, i_texels.uf);
        n_rows.bot = blend_word(i_texels.t01, i_texels.t11, i_texels.uf);
        n_rows.vf  = i_texels.vf;
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            if (rdy6) r_v6 <= i_valid;
            if (rdy7) r_v7 <= r_v6;
        end
    end

    // Advance payload; vertical blend into the output register
    always_ff @(posedge i_clk) begin
        if (rdy6) r_rows <= n_rows;
        if (rdy7) r_color <= blend_word(r_rows.top, r_rows.bot, r_rows.vf);
    end

endmodule

`default_nettype wire

// ===== design/bilinear_texel_sampler_q8.sv =====
// ----------------------------------------------------------------------------
// Bilinear texel sampler, Q8 coordinates
// Texture store loaded by write beats, sampled with bilinear filtering.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one beat per item. tuser = 0 writes texel_color at
//   (texel_x, texel_y); tuser = 1 samples at signed Q8 (u_coord, v_coord).
//   m_axis returns one 32-bit color per sample beat; write beats give none.
//   Throughput is one beat per cycle while m_axis_tready stays high. A
//   sample's color reaches m_axis through four coordinate stages (input,
//   clamp, two modulo stages for horizontal wrap with the index fold after
//   them), the store read, the row blend and the column blend in the output
//   register. The store holds two copies of the texture, each read at two
//   addresses per cycle, so all four neighbors come in one read.
//   A write becomes visible to every sample taken after it.
//   Configuration is written through i_cfg_* while no beat is in flight;
//   the user must keep to this, as the block itself does not enforce it.
//   Reset (synchronous, active low) empties the pipeline and sets width and
//   height to 256 with clamping; texel contents are not cleared.
//   When m_axis_tready is low, each stage holds until the one after it
//   frees; bubbles close up, and s_axis_tready drops only once full.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_texel_sampler_q8
    import tbs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Configuration write port
    input  wire logic               i_cfg_wr_en,
    input  wire logic [IDX_W-1:0]   i_cfg_index,
    input  wire logic [DIM_W-1:0]   i_cfg_wdata,
    // Input stream
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    // texel_x[7:0], texel_y[15:8], texel_color[47:16], u_coord[65:48],
    // v_coord[83:66], zero fill [87:84]
    input  wire logic [87:0]        s_axis_tdata,
    // action[0]
    input  wire logic               s_axis_tuser,
    // Output stream
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // sample_color[31:0]
    output logic [COLOR_W-1:0]      m_axis_tdata
);

    t_cfg    r_cfg;
    t_beat   beat;
    logic    c_valid, c_ready, f_valid, f_ready;
    t_fetch  c_item;
    t_texels f_texels;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tex_width  <= DIM_W'(MAX_WIDTH);
            r_cfg.tex_height <= DIM_W'(MAX_HEIGHT);
            r_cfg.wrap_mode  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_TEX_WIDTH:  r_cfg.tex_width  <= i_cfg_wdata;
                CFG_TEX_HEIGHT: r_cfg.tex_height <= i_cfg_wdata;
                CFG_WRAP_MODE:  r_cfg.wrap_mode  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Unpack the input beat: action, x, y, color, u, v
    assign beat = {s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8],
                   s_axis_tdata[47:16], s_axis_tdata[65:48], s_axis_tdata[83:66]};

    tbs_coord u_coord (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_beat  (beat),
        .o_valid (c_valid),
        .o_item  (c_item),
        .i_ready (c_ready)
    );

    tbs_fetch u_fetch (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (c_valid),
        .o_ready  (c_ready),
        .i_item   (c_item),
        .o_valid  (f_valid),
        .o_texels (f_texels),
        .i_ready  (f_ready)
    );

    tbs_blend u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (f_valid),
        .o_ready  (f_ready),
        .i_texels (f_texels),
        .o_valid  (m_axis_tvalid),
        .o_color  (m_axis_tdata),
        .i_ready  (m_axis_tready)
    );

endmodule

`default_nettype wire
